// ----- hw/rtl/csbi_pkg.sv -----
package csbi_pkg;

	localparam int CS_COUNT_DEF = 8;

	localparam int OP_W         = 2;
	localparam int IDX_W        = 3;
	localparam int WORD_W       = 32;
	localparam int KIND_W       = 2;
	localparam int MASK_N       = 4;
	localparam int MASK_IDX_W   = 2;
	localparam int ENC_W        = 4;
	localparam int ENC_TABLE_N  = 12;
	localparam int SIZE_FIELD_W = 10;
	localparam int SIZE_W       = SIZE_FIELD_W + 1;
	localparam int SIZE_LSB     = 19;
	localparam int LOW_SH_W     = 4;
	localparam int SHIFT_W      = 5;
	localparam int COUNT_W      = 4;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 1;

	localparam logic [OP_W-1:0] OP_LOAD_BASE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_MASK = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_BANK = 2'd2;
	localparam logic [OP_W-1:0] OP_RUN       = 2'd3;

	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BASE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MASK   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE_EN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE     = 1'd1;

	typedef struct packed {
		logic [WORD_W-1:0]  lo_mask;
		logic [WORD_W-1:0]  hi_mask;
		logic [SHIFT_W-1:0] shift_amt;
	} swap_ctrl_t;

	// Low swap bit for each bank encoding; encodings past the table give 0 and are rejected by the setup check.
	function automatic logic [LOW_SH_W-1:0] low_swap_bit(input logic [ENC_W-1:0] enc);
		logic [LOW_SH_W-1:0] r;
		case (enc)
			4'd0:    r = 4'd6;
			4'd1:    r = 4'd7;
			4'd2:    r = 4'd7;
			4'd3:    r = 4'd8;
			4'd4:    r = 4'd8;
			4'd5:    r = 4'd8;
			4'd6:    r = 4'd8;
			4'd7:    r = 4'd8;
			4'd8:    r = 4'd9;
			4'd9:    r = 4'd9;
			4'd10:   r = 4'd8;
			4'd11:   r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/csbi_cmd_if.sv -----
interface csbi_cmd_if import csbi_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [IDX_W-1:0]  reg_index;
	logic [WORD_W-1:0] load_value;

	modport source (output valid, output op, output reg_index, output load_value, input ready);
	modport sink (input valid, input op, input reg_index, input load_value, output ready);
endinterface

// ----- hw/rtl/csbi_rsp_if.sv -----
interface csbi_rsp_if import csbi_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] reg_kind;
	logic [IDX_W-1:0]  out_index;
	logic [WORD_W-1:0] reg_value;
	logic              interleave_disabled;
	logic              last;

	modport source (output valid, output reg_kind, output out_index, output reg_value,
		output interleave_disabled, output last, input ready);
	modport sink (input valid, input reg_kind, input out_index, input reg_value,
		input interleave_disabled, input last, output ready);
endinterface

// ----- hw/rtl/csbi_swap.sv -----
module csbi_swap import csbi_pkg::*; (
	input  logic [WORD_W-1:0] value,
	input  swap_ctrl_t        ctrl,
	output logic [WORD_W-1:0] result
);

	logic [WORD_W-1:0] lo_bits;
	logic [WORD_W-1:0] hi_bits;
	logic [WORD_W-1:0] kept;

	// The two groups never overlap: the low group sits below bit 13, the high one at 19 or above.
	always_comb begin
		lo_bits = value & ctrl.lo_mask;
		hi_bits = value & ctrl.hi_mask;
		kept    = value & ~ctrl.lo_mask & ~ctrl.hi_mask;
		result  = kept | (lo_bits << ctrl.shift_amt) | (hi_bits >> ctrl.shift_amt);
	end

endmodule

// ----- hw/rtl/chip_select_bank_interleave.sv -----
// Loads (base, mask, bank addressing) produce no word.
// A run with interleaving off goes straight to its status word, given once the output slot is free.
// A capable run checks every chip select, takes a setup step and then gives a base word
// per active chip select plus a mask word per even active chip select, each waiting for a
// free output slot, driven by the single sequencer walking the register file through one shared swap unit.
// Reset (arst_n low, asynchronous) clears all stored words, options and the sequencer.
module chip_select_bank_interleave import csbi_pkg::*; #(
	parameter int CS_COUNT = CS_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	csbi_cmd_if.sink              cmd,
	csbi_rsp_if.source            rsp
);

	localparam int CS_W = $clog2(CS_COUNT);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SETUP  = 3'd2;
	localparam logic [2:0] ST_BASE   = 3'd3;
	localparam logic [2:0] ST_MASK   = 3'd4;
	localparam logic [2:0] ST_STATUS = 3'd5;

	logic [WORD_W-1:0] base_q [CS_COUNT];
	logic [WORD_W-1:0] mask_q [MASK_N];
	logic [WORD_W-1:0] bank_q;
	logic              ie_q;
	logic              wide_q;

	logic [2:0]              state_q;
	logic [CS_W-1:0]         cs_q;
	logic [COUNT_W-1:0]      count_q;
	logic [SIZE_FIELD_W-1:0] field_q;
	logic [ENC_W-1:0]        enc_q;
	logic                    dis_q;
	swap_ctrl_t              ctrl_q;

	logic              rsp_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [WORD_W-1:0] value_q;
	logic              odis_q;
	logic              last_q;

	logic [IDX_W-1:0]        idx3;
	logic [MASK_IDX_W-1:0]   pair;
	logic [WORD_W-1:0]       cur_base;
	logic [WORD_W-1:0]       cur_mask;
	logic [SIZE_FIELD_W-1:0] cur_field;
	logic [ENC_W-1:0]        cur_enc;
	logic                    mismatch;
	logic                    cs_last;
	logic                    slot_free;
	logic [CS_COUNT-1:0]     active;
	logic                    beyond;
	logic                    emit;
	logic [WORD_W-1:0]       swap_in;
	logic [WORD_W-1:0]       swap_out;

	logic [SIZE_W-1:0]  size;
	logic [SHIFT_W-1:0] lo_sh;
	logic [SHIFT_W-1:0] hi_sh;
	logic [COUNT_W-1:0] cm1_w;
	logic               count_ok;
	logic               capable;

	function automatic logic [LOW_SH_W-1:0] lowest_set(input logic [SIZE_W-1:0] v);
		logic [LOW_SH_W-1:0] r;
		r = '0;
		for (int i = SIZE_W - 1; i >= 0; i--) begin
			if (v[i]) r = LOW_SH_W'(i);
		end
		return r;
	endfunction

	always_comb begin
		idx3      = IDX_W'(cs_q);
		pair      = idx3[IDX_W-1:1];
		cur_base  = base_q[cs_q];
		cur_mask  = mask_q[pair];
		cur_field = cur_mask[SIZE_LSB +: SIZE_FIELD_W];
		cur_enc   = bank_q[{pair, 2'b00} +: ENC_W];
		mismatch  = cur_base[0] && (count_q != '0) && ((cur_field != field_q) || (cur_enc != enc_q));
		cs_last   = (cs_q == CS_W'(CS_COUNT - 1));
		slot_free = !rsp_valid_q || rsp.ready;
		swap_in   = (state_q == ST_MASK) ? cur_mask : cur_base;
		beyond    = 1'b0;
		for (int i = 0; i < CS_COUNT; i++) begin
			active[i] = |base_q[i][1:0];
			if (i > int'(cs_q) && active[i]) beyond = 1'b1;
		end
		// A word is loaded into the output register this cycle.
		emit      = slot_free && (((state_q == ST_BASE) && active[cs_q]) ||
			(state_q == ST_MASK) || (state_q == ST_STATUS));
	end

	// Setup arithmetic: swap positions and masks from the agreed size and encoding.
	always_comb begin
		size     = {1'b0, field_q} + SIZE_W'(1);
		hi_sh    = SHIFT_W'(lowest_set(size)) + SHIFT_W'(SIZE_LSB);
		lo_sh    = {1'b0, low_swap_bit(enc_q)} + SHIFT_W'(wide_q);
		cm1_w    = count_q - COUNT_W'(1);
		count_ok = (count_q == COUNT_W'(2)) || (count_q == COUNT_W'(4)) || (count_q == COUNT_W'(8));
		capable  = count_ok && (enc_q < ENC_W'(ENC_TABLE_N)) && (hi_sh > lo_sh);
	end

	csbi_swap u_swap (
		.value  (swap_in),
		.ctrl   (ctrl_q),
		.result (swap_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CS_COUNT; i++) base_q[i] <= '0;
			for (int i = 0; i < MASK_N; i++) mask_q[i] <= '0;
			bank_q      <= '0;
			ie_q        <= 1'b0;
			wide_q      <= 1'b0;
			state_q     <= ST_IDLE;
			cs_q        <= '0;
			count_q     <= '0;
			field_q     <= '0;
			enc_q       <= '0;
			dis_q       <= 1'b0;
			ctrl_q      <= '0;
			rsp_valid_q <= 1'b0;
			kind_q      <= KIND_STATUS;
			oidx_q      <= '0;
			value_q     <= '0;
			odis_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INTERLEAVE_EN: ie_q <= cfg_data[0];
					CFG_WIDE_MODE:     wide_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						case (cmd.op)
							OP_LOAD_BASE: begin
								if (int'(cmd.reg_index) < CS_COUNT)
									base_q[cmd.reg_index[CS_W-1:0]] <= cmd.load_value;
							end
							OP_LOAD_MASK: begin
								if (int'(cmd.reg_index) < MASK_N)
									mask_q[cmd.reg_index[MASK_IDX_W-1:0]] <= cmd.load_value;
							end
							OP_LOAD_BANK: bank_q <= cmd.load_value;
							OP_RUN: begin
								cs_q    <= '0;
								count_q <= '0;
								if (!ie_q) begin
									dis_q   <= 1'b0;
									state_q <= ST_STATUS;
								end else begin
									state_q <= ST_CHECK;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					if (cur_base[0]) begin
						count_q <= count_q + COUNT_W'(1);
						if (count_q == '0) begin
							field_q <= cur_field;
							enc_q   <= cur_enc;
						end
					end
					if (mismatch) begin
						dis_q   <= 1'b1;
						state_q <= ST_STATUS;
					end else if (cs_last) begin
						state_q <= ST_SETUP;
					end else begin
						cs_q <= cs_q + CS_W'(1);
					end
				end
				ST_SETUP: begin
					if (capable) begin
						ctrl_q.lo_mask   <= WORD_W'(cm1_w[2:0]) << lo_sh;
						ctrl_q.hi_mask   <= WORD_W'(cm1_w[2:0]) << hi_sh;
						ctrl_q.shift_amt <= hi_sh - lo_sh;
						cs_q             <= '0;
						state_q          <= ST_BASE;
					end else begin
						dis_q   <= 1'b1;
						state_q <= ST_STATUS;
					end
				end
				ST_BASE: begin
					if (!active[cs_q]) begin
						if (cs_last) state_q <= ST_IDLE;
						else cs_q <= cs_q + CS_W'(1);
					end else if (slot_free) begin
						base_q[cs_q] <= swap_out;
						kind_q       <= KIND_BASE;
						oidx_q       <= idx3;
						value_q      <= swap_out;
						odis_q       <= 1'b0;
						// An even chip select is always followed by its mask word.
						last_q       <= idx3[0] && !beyond;
						if (!idx3[0]) state_q <= ST_MASK;
						else if (cs_last) state_q <= ST_IDLE;
						else cs_q <= cs_q + CS_W'(1);
					end
				end
				ST_MASK: begin
					if (slot_free) begin
						mask_q[pair] <= swap_out;
						kind_q       <= KIND_MASK;
						oidx_q       <= IDX_W'(pair);
						value_q      <= swap_out;
						odis_q       <= 1'b0;
						last_q       <= !beyond;
						if (cs_last) begin
							state_q <= ST_IDLE;
						end else begin
							cs_q    <= cs_q + CS_W'(1);
							state_q <= ST_BASE;
						end
					end
				end
				ST_STATUS: begin
					if (slot_free) begin
						kind_q      <= KIND_STATUS;
						oidx_q      <= '0;
						value_q     <= '0;
						odis_q      <= dis_q;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.ready               = (state_q == ST_IDLE);
	assign rsp.valid               = rsp_valid_q;
	assign rsp.reg_kind            = kind_q;
	assign rsp.out_index           = oidx_q;
	assign rsp.reg_value           = value_q;
	assign rsp.interleave_disabled = odis_q;
	assign rsp.last                = last_q;

	a_rewrite_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BASE || state_q == ST_MASK) |->
		(count_q == COUNT_W'(2) || count_q == COUNT_W'(4) || count_q == COUNT_W'(8)))
		else $error("rewrite walk running without a capable chip-select count");

	a_mask_even_cs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MASK) |-> (idx3[0] == 1'b0))
		else $error("mask step on an odd chip select");

	a_shift_amt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BASE || state_q == ST_MASK) |->
		(ctrl_q.shift_amt >= SHIFT_W'(9) && ctrl_q.shift_amt <= SHIFT_W'(23)))
		else $error("swap distance out of range");

	a_base_then_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BASE && active[cs_q] && slot_free && !idx3[0]) |=>
		(state_q == ST_MASK))
		else $error("even chip-select base word not followed by its mask step");

endmodule
